[rtl/rfb_pkg.sv]
// Package for the ring FIFO buffer: operation codes, register indexes,
// payload structs and the control struct between the pointer unit and the top.
// Used by rfb_ptr and ring_fifo_buffer; it depends on nothing else.
`default_nettype none

package rfb_pkg;

    // Default sizes handed to the top level parameters.
    localparam int RFB_DEPTH      = 256;
    localparam int RFB_DATA_BYTES = 4;

    // Operation codes carried in the kind field.
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_FLUSH = 2'd2,
        KIND_NOP   = 2'd3
    } rfb_kind_t;

    // Configuration register indexes.
    localparam logic [7:0] CFG_RING_LENGTH   = 8'd0;
    localparam logic [7:0] CFG_ELEMENT_BYTES = 8'd1;

    // One input item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] write_data;
    } rfb_in_t;

    // One result item.
    typedef struct packed {
        logic [31:0] read_data;
        logic        ok;
        logic [7:0]  occupancy;
    } rfb_out_t;

    // Decision of the pointer unit for the item accepted this cycle.
    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic       ok;
        logic [7:0] occupancy;
    } rfb_op_t;

endpackage

`default_nettype wire

[rtl/rfb_ptr.sv]
// Pointer unit of the ring FIFO buffer: holds the write and read pointers,
// decides full and empty, and computes the occupancy after each item.
// Depends on rfb_pkg.
`default_nettype none

module rfb_ptr
    import rfb_pkg::*;
#(
    parameter int DEPTH = RFB_DEPTH
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [1:0]                  kind,
    input  wire logic [8:0]                  ring_length,
    input  wire logic                        len_write,
    output rfb_op_t                          op,
    output logic [$clog2(DEPTH)-1:0]         wr_addr,
    output logic [$clog2(DEPTH)-1:0]         rd_addr
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LEN_W = (CNT_W > 9) ? CNT_W : 9;

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [LEN_W-1:0] len_ext;
    logic [LEN_W-1:0] n_eff;
    logic [LEN_W-1:0] wp_inc, rp_inc;
    logic [PTR_W-1:0] wp_wrap, rp_wrap;
    logic [LEN_W-1:0] wp_ext, rp_ext;
    logic [LEN_W-1:0] held;
    logic             full, empty;

    // Effective ring length, clamped to the range two to DEPTH.
    always_comb
    begin
        len_ext = LEN_W'(ring_length);
        if (len_ext < LEN_W'(2))
            n_eff = LEN_W'(2);
        else if (len_ext > LEN_W'(DEPTH))
            n_eff = LEN_W'(DEPTH);
        else
            n_eff = len_ext;
    end

    // Incremented pointers, wrapped at the ring length.
    always_comb
    begin
        wp_inc  = LEN_W'(wp_reg) + LEN_W'(1);
        rp_inc  = LEN_W'(rp_reg) + LEN_W'(1);
        wp_wrap = (wp_inc == n_eff) ? '0 : wp_inc[PTR_W-1:0];
        rp_wrap = (rp_inc == n_eff) ? '0 : rp_inc[PTR_W-1:0];
        full    = (wp_wrap == rp_reg);
        empty   = (wp_reg == rp_reg);
    end

    // Operation decision, next pointer values and the occupancy after the item.
    always_comb
    begin
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        op.wr_en     = 1'b0;
        op.rd_en     = 1'b0;
        op.ok        = 1'b0;
        case (kind)
            KIND_WRITE:
            begin
                if (!full)
                begin
                    op.wr_en = accept;
                    op.ok    = 1'b1;
                    if (accept)
                        wp_next = wp_wrap;
                end
            end
            KIND_READ:
            begin
                if (!empty)
                begin
                    op.rd_en = accept;
                    op.ok    = 1'b1;
                    if (accept)
                        rp_next = rp_wrap;
                end
            end
            KIND_FLUSH:
            begin
                op.ok = 1'b1;
                if (accept)
                begin
                    wp_next = '0;
                    rp_next = '0;
                end
            end
            default:
            begin
                op.ok = 1'b0;
            end
        endcase
        // A ring length write restarts the ring.
        if (len_write)
        begin
            wp_next = '0;
            rp_next = '0;
        end
        // Occupancy after the item, modulo the ring length.
        wp_ext = LEN_W'(wp_next);
        rp_ext = LEN_W'(rp_next);
        if (wp_ext >= rp_ext)
            held = wp_ext - rp_ext;
        else
            held = wp_ext + n_eff - rp_ext;
        op.occupancy = held[7:0];
    end

    assign wr_addr = wp_reg;
    assign rd_addr = rp_reg;

    // Pointer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
        end
    end

endmodule

`default_nettype wire

[rtl/ring_fifo_buffer.sv]
// Top level of the ring FIFO buffer: configuration registers, slot memory
// and result stage. Depends on rfb_pkg and rfb_ptr.
//
// Channel   Direction  Handshake                 Payload
// cmd       in         start high, busy low      rfb_in_t  (kind, write_data)
// result    out        done strobe, one cycle    rfb_out_t (read_data, ok, occupancy)
// cfg       in         cfg_valid and cfg_ready   cfg_index, cfg_data
//
// One item is accepted every cycle; busy stays low.
// Each result appears in the cycle after its item is accepted, as the
// slot memory has a registered read port.
// Reset clears the pointers and loads ring_length 256 and element_bytes 1;
// the slot memory is not cleared, and only written slots are ever read.
// The receiver cannot stall, so results never wait.
`default_nettype none

module ring_fifo_buffer
    import rfb_pkg::*;
#(
    parameter int DEPTH      = RFB_DEPTH,
    parameter int DATA_BYTES = RFB_DATA_BYTES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  rfb_in_t          cmd,
    output logic             done,
    output rfb_out_t         result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int PTR_W     = $clog2(DEPTH);
    localparam int LIM_BYTES = (DATA_BYTES < 4) ? DATA_BYTES : 4;
    localparam int MEM_W     = 8 * LIM_BYTES;

    logic [8:0]       ring_length_reg;
    logic [2:0]       element_bytes_reg;
    logic             accept;
    logic             cfg_write;
    logic             len_write;
    rfb_op_t          op;
    logic [PTR_W-1:0] wr_addr, rd_addr;
    logic [2:0]       bytes_eff;
    logic [MEM_W-1:0] data_mask;
    logic [MEM_W-1:0] mem [DEPTH];
    logic [MEM_W-1:0] mem_q_reg;
    logic             done_reg;
    logic             ok_reg;
    logic             rd_hit_reg;
    logic [7:0]       occ_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign cfg_write = cfg_valid && cfg_ready;
    assign len_write = cfg_write && (cfg_index == CFG_RING_LENGTH);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_length_reg   <= 9'd256;
            element_bytes_reg <= 3'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_RING_LENGTH:   ring_length_reg   <= cfg_data[8:0];
                CFG_ELEMENT_BYTES: element_bytes_reg <= cfg_data[2:0];
                default:           ;
            endcase
        end
    end

    // Pointer unit.
    rfb_ptr #(
        .DEPTH(DEPTH)
    ) u_ptr (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .kind       (cmd.kind),
        .ring_length(ring_length_reg),
        .len_write  (len_write),
        .op         (op),
        .wr_addr    (wr_addr),
        .rd_addr    (rd_addr)
    );

    // Byte mask from the clamped element size.
    always_comb
    begin
        if (element_bytes_reg == 3'd0)
            bytes_eff = 3'd1;
        else if (element_bytes_reg > 3'(LIM_BYTES))
            bytes_eff = 3'(LIM_BYTES);
        else
            bytes_eff = element_bytes_reg;
        for (int i = 0; i < LIM_BYTES; i++)
        begin
            data_mask[i*8 +: 8] = (3'(i) < bytes_eff) ? 8'hFF : 8'h00;
        end
    end

    // Slot memory: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (op.wr_en)
            mem[wr_addr] <= MEM_W'(cmd.write_data) & data_mask;
        if (op.rd_en)
            mem_q_reg <= mem[rd_addr];
    end

    // Result stage, aligned with the memory read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        ok_reg     <= op.ok;
        rd_hit_reg <= op.rd_en;
        occ_reg    <= op.occupancy;
    end

    assign done             = done_reg;
    assign result.read_data = rd_hit_reg ? 32'(mem_q_reg) : 32'd0;
    assign result.ok        = ok_reg;
    assign result.occupancy = occ_reg;

    // Every accepted item gives a result in the next cycle.
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("result strobe missing after an accepted item");

    // The memory never sees a write and a read for the same item.
    a_one_port_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(op.wr_en && op.rd_en))
        else $error("write and read issued together");

    // A failed item returns zero read data.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.ok) |-> (result.read_data == 32'd0))
        else $error("nonzero read data on a failed item");

    // A flush reports success and an empty ring.
    a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.kind == KIND_FLUSH) |=> (result.ok && result.occupancy == 8'd0))
        else $error("flush did not empty the ring");

endmodule

`default_nettype wire

[test/ring_fifo_buffer_tb.sv]
// Self-checking testbench for ring_fifo_buffer: a directed table, then random
// phases of write, read, flush and no-op items under changing ring settings.
// Depends on rfb_pkg and the ring_fifo_buffer RTL.
`timescale 1ns / 100ps

module ring_fifo_buffer_tb;
    import rfb_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int ITEM_TARGET    = 1800;
    localparam int N_DIRECTED     = 40;

    // One row of the directed table: a register write or a command item,
    // with an optional hand-written expected result.
    typedef struct packed {
        logic       cfg_row;
        logic [7:0] index;
        logic [31:0] data;
        rfb_kind_t  kind;
        logic       typed;
        rfb_out_t   want;
    } step_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    rfb_in_t     cmd;
    logic        done;
    rfb_out_t    result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [31:0] cfg_data;

    // Shadow copy of the ring: slots, pointers and both registers.
    logic [31:0] shadow_slots [RFB_DEPTH];
    int unsigned shadow_wr;
    int unsigned shadow_rd;
    logic [8:0]  shadow_length;
    logic [2:0]  shadow_bytes;

    rfb_out_t    pending_results [$];
    bit          row_typed;
    rfb_out_t    row_want;
    rfb_out_t    predicted;
    rfb_out_t    oldest;
    int unsigned mismatches;
    int unsigned quiet_cycles;
    bit          progress;

    ring_fifo_buffer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Directed table. Rows with typed set carry a result read straight off
    // the behavior; the others are checked against the shadow ring.
    step_row_t directed_rows [N_DIRECTED] = '{
        // Reset state: 256 slots, one byte per element, empty ring.
        '{1'b0, 8'd0, 32'h0000_0000, KIND_READ,  1'b1, '{32'h0, 1'b0, 8'd0}},
        '{1'b0, 8'd0, 32'hFFFF_FFFF, KIND_NOP,   1'b1, '{32'h0, 1'b0, 8'd0}},
        '{1'b0, 8'd0, 32'hFFFF_FFFF, KIND_FLUSH, 1'b1, '{32'h0, 1'b1, 8'd0}},
        '{1'b0, 8'd0, 32'hFFFF_FFFF, KIND_WRITE, 1'b1, '{32'h0, 1'b1, 8'd1}},
        '{1'b0, 8'd0, 32'h0000_0000, KIND_WRITE, 1'b1, '{32'h0, 1'b1, 8'd2}},
        '{1'b0, 8'd0, 32'h0000_0000, KIND_READ,  1'b1, '{32'hFF, 1'b1, 8'd1}},
        '{1'b0, 8'd0, 32'h0000_0000, KIND_READ,  1'b1, '{32'h0, 1'b1, 8'd0}},
        '{1'b0, 8'd0, 32'h0000_0000, KIND_READ,  1'b1, '{32'h0, 1'b0, 8'd0}},
        // Smallest ring: one element fills it.
        '{1'b1, CFG_RING_LENGTH, 32'd2, KIND_NOP, 1'b0, '0},
        '{1'b0, 8'd0, 32'hA5A5_A5A5, KIND_WRITE, 1'b1, '{32'h0, 1'b1, 8'd1}},
        '{1'b0, 8'd0, 32'h5A5A_5A5A, KIND_WRITE, 1'b1, '{32'h0, 1'b0, 8'd1}},
        '{1'b0, 8'd0, 32'h0000_0000, KIND_NOP,   1'b1, '{32'h0, 1'b0, 8'd1}},
        '{1'b0, 8'd0, 32'h0000_0000, KIND_READ,  1'b1, '{32'hA5, 1'b1, 8'd0}},
        // Full-width element survives a later narrowing of the width.
        '{1'b1, CFG_ELEMENT_BYTES, 32'd4, KIND_NOP, 1'b0, '0},
        '{1'b0, 8'd0, 32'hDEAD_BEEF, KIND_WRITE, 1'b1, '{32'h0, 1'b1, 8'd1}},
        '{1'b1, CFG_ELEMENT_BYTES, 32'd0, KIND_NOP, 1'b0, '0},
        '{1'b0, 8'd0, 32'h0000_0000, KIND_READ,  1'b1, '{32'hDEAD_BEEF, 1'b1, 8'd0}},
        '{1'b0, 8'd0, 32'h1234_5678, KIND_WRITE, 1'b1, '{32'h0, 1'b1, 8'd1}},
        '{1'b0, 8'd0, 32'h0000_0000, KIND_FLUSH, 1'b1, '{32'h0, 1'b1, 8'd0}},
        '{1'b0, 8'd0, 32'h0000_0000, KIND_READ,  1'b1, '{32'h0, 1'b0, 8'd0}},
        // Length below the minimum acts as two slots.
        '{1'b1, CFG_RING_LENGTH, 32'd1, KIND_NOP, 1'b0, '0},
        '{1'b0, 8'd0, 32'h8000_0001, KIND_WRITE, 1'b0, '0},
        '{1'b0, 8'd0, 32'h7FFF_FFFE, KIND_WRITE, 1'b0, '0},
        // Length above the maximum acts as the full depth and clears pointers.
        '{1'b1, CFG_RING_LENGTH, 32'hFFFF_FFFF, KIND_NOP, 1'b0, '0},
        '{1'b0, 8'd0, 32'h0000_0000, KIND_READ,  1'b1, '{32'h0, 1'b0, 8'd0}},
        '{1'b1, CFG_ELEMENT_BYTES, 32'hFFFF_FFFF, KIND_NOP, 1'b0, '0},
        '{1'b0, 8'd0, 32'hFFFF_FFFF, KIND_WRITE, 1'b0, '0},
        '{1'b0, 8'd0, 32'h8000_0001, KIND_WRITE, 1'b0, '0},
        // Writes beyond the register list change nothing.
        '{1'b1, 8'hFF, 32'h0000_0000, KIND_NOP, 1'b0, '0},
        '{1'b1, 8'h02, 32'hFFFF_FFFF, KIND_NOP, 1'b0, '0},
        '{1'b0, 8'd0, 32'h0000_0000, KIND_READ,  1'b0, '0},
        // Rewriting the length empties the ring.
        '{1'b1, CFG_RING_LENGTH, 32'd3, KIND_NOP, 1'b0, '0},
        '{1'b0, 8'd0, 32'h0000_0000, KIND_READ,  1'b1, '{32'h0, 1'b0, 8'd0}},
        '{1'b1, CFG_ELEMENT_BYTES, 32'd2, KIND_NOP, 1'b0, '0},
        '{1'b0, 8'd0, 32'hCAFE_F00D, KIND_WRITE, 1'b0, '0},
        '{1'b0, 8'd0, 32'h0BAD_F00D, KIND_WRITE, 1'b0, '0},
        '{1'b0, 8'd0, 32'h0000_0001, KIND_WRITE, 1'b0, '0},
        '{1'b1, CFG_ELEMENT_BYTES, 32'd3, KIND_NOP, 1'b0, '0},
        '{1'b0, 8'd0, 32'h0000_0000, KIND_READ,  1'b0, '0},
        '{1'b0, 8'd0, 32'hFFFF_FFFF, KIND_WRITE, 1'b0, '0}
    };

    // Effective ring length: the register clamped to 2..depth.
    function automatic int unsigned ring_span();
        int unsigned n;
        n = shadow_length;
        if (n < 2) n = 2;
        if (n > RFB_DEPTH) n = RFB_DEPTH;
        return n;
    endfunction

    // Apply one command item to the shadow ring and return its result.
    function automatic rfb_out_t ring_predict(rfb_in_t item);
        rfb_out_t    res;
        int unsigned n;
        int unsigned nxt;
        int unsigned nbytes;
        logic [31:0] mask;
        n = ring_span();
        res = '0;
        shadow_wr = shadow_wr % n;
        shadow_rd = shadow_rd % n;
        case (rfb_kind_t'(item.kind))
            KIND_WRITE:
            begin
                nxt = (shadow_wr + 1) % n;
                if (nxt != shadow_rd)
                begin
                    nbytes = shadow_bytes;
                    if (nbytes < 1) nbytes = 1;
                    if (nbytes > 4) nbytes = 4;
                    mask = (nbytes == 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * nbytes)) - 1);
                    shadow_slots[shadow_wr] = item.write_data & mask;
                    shadow_wr = nxt;
                    res.ok = 1'b1;
                end
            end
            KIND_READ:
            begin
                if (shadow_rd != shadow_wr)
                begin
                    res.read_data = shadow_slots[shadow_rd];
                    shadow_rd = (shadow_rd + 1) % n;
                    res.ok = 1'b1;
                end
            end
            KIND_FLUSH:
            begin
                shadow_wr = 0;
                shadow_rd = 0;
                res.ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        res.occupancy = 8'((shadow_wr + n - shadow_rd) % n);
        return res;
    endfunction

    // Monitor: track accepted register writes and items, check each result
    // against the oldest expectation, and watch for a stalled run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            progress = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                progress = 1'b1;
                case (cfg_index)
                    CFG_RING_LENGTH:
                    begin
                        shadow_length = cfg_data[8:0];
                        shadow_wr = 0;
                        shadow_rd = 0;
                    end
                    CFG_ELEMENT_BYTES: shadow_bytes = cfg_data[2:0];
                    default:
                    begin
                    end
                endcase
            end
            if (start && !busy)
            begin
                progress = 1'b1;
                predicted = ring_predict(cmd);
                pending_results.push_back(row_typed ? row_want : predicted);
            end
            if (done)
            begin
                progress = 1'b1;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing expected: read_data=%h ok=%b occ=%0d",
                                 $time, result.read_data, result.ok, result.occupancy);
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (result.read_data !== oldest.read_data || result.ok !== oldest.ok ||
                        result.occupancy !== oldest.occupancy)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected read_data=%h ok=%b occ=%0d, got %h %b %0d",
                                     $time, oldest.read_data, oldest.ok, oldest.occupancy,
                                     result.read_data, result.ok, result.occupancy);
                    end
                end
            end
            quiet_cycles = progress ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Lower start and wait until every expected result has come back.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Write one register while the ring is idle.
    task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Present one item after a gap and wait until it is taken.
    task automatic send_item(input rfb_kind_t kind, input logic [31:0] data, input int gap,
                             input bit typed, input rfb_out_t want);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        row_typed = typed;
        row_want  = want;
        cmd   <= '{kind: kind, write_data: data};
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // Stimulus: reset, directed table, then random phases.
    initial
    begin
        int unsigned sent;
        int unsigned phase_items;
        int unsigned write_share;
        int unsigned pick;
        int unsigned span;
        int          gap;
        bit          no_gaps;
        bit          first_phase;
        logic [31:0] len_val;
        rfb_kind_t   kind;

        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        row_typed   = 1'b0;
        row_want    = '0;
        mismatches  = 0;
        quiet_cycles = 0;
        shadow_wr   = 0;
        shadow_rd   = 0;
        shadow_length = 9'd256;
        shadow_bytes  = 3'd1;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (directed_rows[i].cfg_row)
                write_reg(directed_rows[i].index, directed_rows[i].data);
            else
                send_item(directed_rows[i].kind, directed_rows[i].data, $urandom_range(0, 2),
                          directed_rows[i].typed, directed_rows[i].want);
        end

        // Random phases: each sets a ring length, maybe an element width and maybe an unlisted
        // register, and a mix of writes, reads, flushes and no-ops that fills, empties or balances the ring.
        sent = 0;
        first_phase = 1'b1;
        while (sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 9);
            if (first_phase)      len_val = 32'd256;
            else if (pick <= 4)   len_val = $urandom_range(2, 9);
            else if (pick == 5)   len_val = $urandom_range(10, 64);
            else if (pick == 6)   len_val = $urandom_range(0, 511);
            else if (pick == 7)   len_val = ($urandom_range(0, 1) != 0) ? 32'd256 : 32'd511;
            else                  len_val = $urandom_range(0, 1);
            write_reg(CFG_RING_LENGTH, ($urandom & 32'hFFFF_FE00) | len_val);
            if ($urandom_range(0, 1) != 0)
                write_reg(CFG_ELEMENT_BYTES, ($urandom & 32'hFFFF_FFF8) | $urandom_range(0, 7));
            if ($urandom_range(0, 7) == 0)
                write_reg(8'($urandom_range(2, 255)), $urandom);

            span = ring_span();
            phase_items = (span >= 64) ? $urandom_range(400, 600) : $urandom_range(40, 120);
            pick = first_phase ? 1 : $urandom_range(0, 2);
            write_share = (pick == 0) ? 50 : ((pick == 1) ? 78 : 30);
            no_gaps = ($urandom_range(0, 3) == 0);
            first_phase = 1'b0;

            for (int k = 0; k < phase_items && sent < ITEM_TARGET; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 2)                      kind = KIND_FLUSH;
                else if (pick < 4)                 kind = KIND_NOP;
                else if (pick < 4 + write_share)   kind = KIND_WRITE;
                else                               kind = KIND_READ;
                gap = no_gaps ? 0 : $urandom_range(0, 4);
                // Now and then hold the sender until the ring has answered everything.
                if ($urandom_range(0, 99) == 0)
                    drain_results();
                send_item(kind, $urandom, gap, 1'b0, '0);
                if (kind != KIND_NOP)
                    sent++;
            end
        end

        // Let the last results arrive, with a bound.
        @(negedge clk);
        start <= 1'b0;
        for (int w = 0; w < 200 && pending_results.size() != 0; w++)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            mismatches++;
            $display("%0d expected results never arrived", pending_results.size());
        end

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
